// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked out of reset
`define FFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication, checked out of reset
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/ffa_pkg.sv =====
// Types and constants for the first-fit block allocator
package ffa_pkg;

    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 17;
    localparam int MIN_CAPACITY = 24;
    localparam int MAX_BLOCKS   = 2048;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W = 16;
    localparam int CAP_W  = 17;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [CAP_W-1:0]  cap;
        logic              free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
    } tbl_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_ABS,
        S_ABS_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_INS_NEW,
        S_INS_OWN,
        S_FIN
    } state_t;

endpackage

// ===== sv/ffa_ram.sv =====
// Generic simple dual-port RAM with registered read
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/ffa_table.sv =====
// Block table: RAM plus reset value of the first entry
`include "assert_macros.svh"
module ffa_table (
    input  logic            clk,
    input  logic            rst_n,
    input  ffa_pkg::tbl_req_t req,
    output ffa_pkg::entry_t   rdata
);
    import ffa_pkg::*;

    logic   e0_written_reg;
    logic   e0_written_next;
    logic   rd_zero_reg;
    logic   rd_zero_next;
    logic [ENTRY_W-1:0] ram_q;
    entry_t reset_entry;

    ffa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_BLOCKS)
    ) u_ram (
        .clk  (clk),
        .we   (req.we),
        .waddr(req.waddr),
        .wdata(req.wdata),
        .re   (req.re),
        .raddr(req.raddr),
        .rdata(ram_q)
    );

    always_comb
    begin
        e0_written_next = e0_written_reg || (req.we && req.waddr == '0);
        rd_zero_next    = req.re ? (req.raddr == '0) : rd_zero_reg;
        reset_entry.start = '0;
        reset_entry.cap   = CAP_W'(ARENA_BYTES - HEADER_BYTES);
        reset_entry.free  = 1'b1;
        rdata = (rd_zero_reg && !e0_written_reg) ? reset_entry : entry_t'(ram_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_written_reg <= 1'b0;
            rd_zero_reg    <= 1'b0;
        end
        else
        begin
            e0_written_reg <= e0_written_next;
            rd_zero_reg    <= rd_zero_next;
        end
    end

    `FFA_ASSERT(a_no_rw_same, !(req.re && req.we && req.raddr == req.waddr), "read and write collide")
    `FFA_ASSERT_IMP(a_e0_sticky, e0_written_reg, ##1 e0_written_reg, "entry 0 flag dropped")
endmodule

// ===== sv/first_fit_block_allocator.sv =====
// Top level: first-fit allocator sequencer over the block table
// One item at a time: start is taken while busy is low, and done marks result_address and
// status for one cycle, which the receiver must take then. The block table sits in one RAM
// with one read and one write port, and its reads are registered. The walk passes used
// blocks. A free block visited, or the block named by a free, absorbs the free blocks
// just after it. Each merge moves later entries down; a split moves later entries up.
// A null free goes straight to done.
`include "assert_macros.svh"
module first_fit_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [16:0] request_size,
    input  logic [15:0] payload_address,
    output logic        done,
    output logic [15:0] result_address,
    output logic [1:0]  status
);
    import ffa_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    entry_t            cur_reg, cur_next;
    logic [CAP_W-1:0]  want_reg, want_next;
    logic              op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    logic [1:0]        stat_reg, stat_next;

    tbl_req_t req;
    entry_t   rdata;

    logic [CNT_W-1:0]  i_inc;
    logic [CNT_W-1:0]  j_dec;
    logic [CAP_W:0]    split_need;
    logic [CAP_W:0]    hit_sum;
    logic              split_ok;

    ffa_table u_table (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rdata(rdata)
    );

    assign i_inc      = i_reg + CNT_W'(1);
    assign j_dec      = j_reg - CNT_W'(1);
    assign split_need = {1'b0, want_reg} + (CAP_W+1)'(HEADER_BYTES + MIN_CAPACITY);
    assign hit_sum    = {2'b00, rdata.start} + (CAP_W+1)'(HEADER_BYTES);
    assign split_ok   = ({1'b0, cur_reg.cap} >= split_need) && (count_reg < CNT_W'(MAX_BLOCKS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (op == OP_FREE && payload_address == '0) ? S_FIN : S_RD;
                end
            end
            S_RD:      state_next = (i_reg >= count_reg) ? S_FIN : S_CHK;
            S_CHK:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    state_next = rdata.free ? S_ABS : S_RD;
                end
                else
                begin
                    state_next = (hit_sum == {2'b00, addr_reg}) ? S_ABS : S_RD;
                end
            end
            S_ABS:     state_next = (i_inc < count_reg) ? S_ABS_CHK : S_DECIDE;
            S_ABS_CHK: state_next = rdata.free ? S_DEL_RD : S_DECIDE;
            S_DEL_RD:  state_next = (j_reg < count_reg) ? S_DEL_WR : S_ABS;
            S_DEL_WR:  state_next = S_DEL_RD;
            S_DECIDE:
            begin
                priority if (op_reg == OP_FREE)
                begin
                    state_next = S_FIN;
                end
                else if (cur_reg.cap >= want_reg)
                begin
                    state_next = split_ok ? S_INS_RD : S_FIN;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_INS_RD:  state_next = (j_reg > i_inc) ? S_INS_WR : S_INS_NEW;
            S_INS_WR:  state_next = S_INS_RD;
            S_INS_NEW: state_next = S_INS_OWN;
            S_INS_OWN: state_next = S_FIN;
            S_FIN:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        want_next  = want_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        req        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = op;
                    addr_next = payload_address;
                    want_next = (request_size < CAP_W'(MIN_CAPACITY)) ?
                                CAP_W'(MIN_CAPACITY) : request_size;
                    i_next    = '0;
                    res_next  = '0;
                    stat_next = ST_OK;
                end
            end
            S_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    stat_next = (op_reg == OP_ALLOC) ? ST_NOMEM : ST_BADADDR;
                end
                else
                begin
                    req.re    = 1'b1;
                    req.raddr = i_reg[IDX_W-1:0];
                end
            end
            S_CHK:
            begin
                cur_next = rdata;
                if (op_reg == OP_ALLOC)
                begin
                    if (!rdata.free)
                    begin
                        i_next = i_inc;
                    end
                end
                else if (hit_sum == {2'b00, addr_reg})
                begin
                    cur_next.free = 1'b1;
                end
                else
                begin
                    i_next = i_inc;
                end
            end
            S_ABS:
            begin
                if (i_inc < count_reg)
                begin
                    req.re    = 1'b1;
                    req.raddr = i_inc[IDX_W-1:0];
                end
            end
            S_ABS_CHK:
            begin
                if (rdata.free)
                begin
                    cur_next.cap = cur_reg.cap + CAP_W'(HEADER_BYTES) + rdata.cap;
                    j_next       = i_reg + CNT_W'(2);
                end
            end
            S_DEL_RD:
            begin
                if (j_reg < count_reg)
                begin
                    req.re    = 1'b1;
                    req.raddr = j_reg[IDX_W-1:0];
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            S_DEL_WR:
            begin
                req.we    = 1'b1;
                req.waddr = j_dec[IDX_W-1:0];
                req.wdata = rdata;
                j_next    = j_reg + CNT_W'(1);
            end
            S_DECIDE:
            begin
                req.waddr = i_reg[IDX_W-1:0];
                req.wdata = cur_reg;
                priority if (op_reg == OP_FREE)
                begin
                    req.we = 1'b1;
                end
                else if (cur_reg.cap >= want_reg)
                begin
                    if (split_ok)
                    begin
                        j_next = count_reg;
                    end
                    else
                    begin
                        req.we         = 1'b1;
                        req.wdata.free = 1'b0;
                        res_next       = cur_reg.start + ADDR_W'(HEADER_BYTES);
                        stat_next      = ST_OK;
                    end
                end
                else
                begin
                    req.we = 1'b1;
                    i_next = i_inc;
                end
            end
            S_INS_RD:
            begin
                if (j_reg > i_inc)
                begin
                    req.re    = 1'b1;
                    req.raddr = j_dec[IDX_W-1:0];
                end
            end
            S_INS_WR:
            begin
                req.we    = 1'b1;
                req.waddr = j_reg[IDX_W-1:0];
                req.wdata = rdata;
                j_next    = j_dec;
            end
            S_INS_NEW:
            begin
                req.we          = 1'b1;
                req.waddr       = i_inc[IDX_W-1:0];
                req.wdata.start = cur_reg.start + ADDR_W'(HEADER_BYTES) + want_reg[ADDR_W-1:0];
                req.wdata.cap   = cur_reg.cap - want_reg - CAP_W'(HEADER_BYTES);
                req.wdata.free  = 1'b1;
                count_next      = count_reg + CNT_W'(1);
            end
            S_INS_OWN:
            begin
                req.we          = 1'b1;
                req.waddr       = i_reg[IDX_W-1:0];
                req.wdata.start = cur_reg.start;
                req.wdata.cap   = want_reg;
                req.wdata.free  = 1'b0;
                res_next        = cur_reg.start + ADDR_W'(HEADER_BYTES);
                stat_next       = ST_OK;
            end
            S_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        want_reg <= want_next;
        op_reg   <= op_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_FIN);
    assign result_address = res_reg;
    assign status         = stat_reg;

    `FFA_ASSERT(a_count_range, count_reg != '0 && count_reg <= CNT_W'(MAX_BLOCKS), "block count out of range")
    `FFA_ASSERT_IMP(a_done_once, done, ##1 !done, "done held for two cycles")
    `FFA_ASSERT_IMP(a_fail_zero, done && status != ST_OK, result_address == '0, "failure with address")
endmodule
